FILE: sv/rgsl_pkg.sv
// shared types and constants for the replay gain soft limiter
`timescale 1ns / 1ps
package rgsl_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 20;
  localparam int OUT_W    = 16;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;  // |sample| * gain, Q.39
  localparam int AMP_W    = PROD_W + 1;         // after the optional doubling
  localparam int U_W      = 42;                 // tanh argument below the saturation point
  localparam int FRAC_W   = 30;
  localparam int TAB_W    = 32;
  localparam int LIN_W    = 15;

  localparam int TANH_ENTRIES_DEF = 256;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);
  localparam logic [LIN_W-1:0]  OUT_MAX    = LIN_W'(32767);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SCALE     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOSTER_ENABLE = 1'b1;

  // pipeline register stages
  localparam int NSTG      = 6;
  localparam int ST_MUL    = 0;
  localparam int ST_RANGE  = 1;
  localparam int ST_POS    = 2;
  localparam int ST_TAB    = 3;
  localparam int ST_DIFF   = 4;
  localparam int ST_OUT    = 5;

  typedef struct packed {
    logic [NSTG-1:0] en;   // stage register may load
    logic [NSTG-1:0] vld;  // stage register holds a word
  } pipe_ctl_t;

  typedef struct packed {
    logic             neg;
    logic             knee;
    logic             ksat;
    logic             lsat;
    logic [LIN_W-1:0] lin;
    logic [U_W-1:0]   u;
  } gain_bus_t;

endpackage

FILE: sv/rgsl_ctl.sv
// valid bits and per-stage load enables of the pipeline
`timescale 1ns / 1ps
module rgsl_ctl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                out_ready,
  output rgsl_pkg::pipe_ctl_t ctl
);
  import rgsl_pkg::*;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // a stage loads when it is empty or its word moves on
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign ctl.en  = en;
  assign ctl.vld = vld;

endmodule

FILE: sv/rgsl_gain.sv
// gain multiply, booster doubling and range split into linear or knee path
`timescale 1ns / 1ps
module rgsl_gain (
  input  logic                                 clk,
  input  rgsl_pkg::pipe_ctl_t                  ctl,
  input  logic signed [rgsl_pkg::SAMPLE_W-1:0] sample_in,
  input  logic        [rgsl_pkg::GAIN_W-1:0]   gain_scale,
  input  logic                                 booster_enable,
  output rgsl_pkg::gain_bus_t                  gbus
);
  import rgsl_pkg::*;

  localparam logic [AMP_W-1:0] HALF = AMP_W'(1) << 38;

  logic [SAMPLE_W-1:0] smag;
  logic [PROD_W-1:0]   a1;
  logic                neg1;
  logic [AMP_W-1:0]    a2;
  logic [AMP_W-1:0]    dk;
  logic [53:0]         lin_scaled;
  gain_bus_t           gbus_next;

  // magnitude of the sample; the most negative code maps to 2^23
  assign smag = sample_in[SAMPLE_W-1] ? SAMPLE_W'(-sample_in) : SAMPLE_W'(sample_in);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_MUL]) begin
      a1   <= PROD_W'(smag) * PROD_W'(gain_scale);
      neg1 <= sample_in[SAMPLE_W-1];
    end
  end

  always_comb begin
    a2 = booster_enable ? {a1, 1'b0} : {1'b0, a1};
    // times 32767 as shift and subtract, then back to integer
    lin_scaled = {a2[38:0], 15'b0} - {15'b0, a2[38:0]};
    dk = a2 - HALF;
    gbus_next.neg  = neg1;
    gbus_next.knee = booster_enable && (a2 > HALF);
    gbus_next.lsat = |a2[AMP_W-1:39];
    gbus_next.lin  = lin_scaled[53:39];
    // tanh argument 2*(a - 0.5) at or beyond 8 takes the last table point
    gbus_next.ksat = |dk[AMP_W-1:41];
    gbus_next.u    = {dk[40:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_RANGE]) begin
      gbus <= gbus_next;
    end
  end

endmodule

FILE: sv/rgsl_knee.sv
// tanh table lookup, interpolation and final scale, clamp and sign
`timescale 1ns / 1ps
module rgsl_knee #(
  parameter int TANH_ENTRIES = rgsl_pkg::TANH_ENTRIES_DEF
) (
  input  logic                              clk,
  input  rgsl_pkg::pipe_ctl_t               ctl,
  input  rgsl_pkg::gain_bus_t               gbus,
  output logic signed [rgsl_pkg::OUT_W-1:0] sample_out
);
  import rgsl_pkg::*;

  localparam int IW = $clog2(TANH_ENTRIES + 1);
  localparam int PW = U_W + IW;
  localparam logic [63:0] Q30    = 64'd1 << 30;
  localparam logic [63:0] Y_STEP = (64'd16 << 30) / TANH_ENTRIES;

  typedef logic [TANH_ENTRIES:0][TAB_W-1:0] tab_t;

  // shift-subtract divide, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    if (den == '0) begin
      return '1;
    end
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // tanh(8k/N) in Q2.30 from a series for exp(-16/N) and repeated powers
  function automatic tab_t build_tab();
    tab_t        tab;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] p;
    logic [63:0] w;
    logic [63:0] q;
    term = Q30;
    e    = Q30;
    p    = Q30;
    for (int n = 1; n <= 12; n++) begin
      w    = term * Y_STEP;
      term = udiv64(w >> 30, 64'(n));
      if (n[0]) begin
        e = e - term;
      end else begin
        e = e + term;
      end
    end
    tab[0] = '0;
    for (int k = 1; k <= TANH_ENTRIES; k++) begin
      w = p * e;
      p = w >> 30;
      q = udiv64((Q30 - p) << 30, Q30 + p);
      tab[k] = q[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam tab_t TANH_TAB = build_tab();
  localparam logic [IW-1:0] LAST = IW'(TANH_ENTRIES);

  // stage: table position
  logic [PW-1:0]     pos;
  logic              neg2, knee2, ksat2, lsat2;
  logic [LIN_W-1:0]  lin2;
  logic [IW-1:0]     idx2;
  logic [FRAC_W-1:0] f2;

  assign pos = PW'(gbus.u) * PW'(TANH_ENTRIES);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_POS]) begin
      neg2  <= gbus.neg;
      knee2 <= gbus.knee;
      ksat2 <= gbus.ksat;
      lsat2 <= gbus.lsat;
      lin2  <= gbus.lin;
      idx2  <= pos[PW-1:U_W];
      f2    <= pos[U_W-1:12];
    end
  end

  // stage: table read, two neighboring points
  logic              neg3, knee3, lsat3;
  logic [LIN_W-1:0]  lin3;
  logic [TAB_W-1:0]  lo3, hi3;
  logic [FRAC_W-1:0] f3;

  always_ff @(posedge clk) begin
    if (ctl.en[ST_TAB]) begin
      neg3  <= neg2;
      knee3 <= knee2;
      lsat3 <= lsat2;
      lin3  <= lin2;
      f3    <= f2;
      if (ksat2) begin
        lo3 <= TANH_TAB[LAST];
        hi3 <= TANH_TAB[LAST];
      end else begin
        lo3 <= TANH_TAB[idx2];
        hi3 <= TANH_TAB[idx2 + IW'(1)];
      end
    end
  end

  // stage: interpolation step
  logic                    dneg;
  logic [TAB_W-1:0]        dmag;
  logic [TAB_W+FRAC_W-1:0] dprod;
  logic                    neg4, knee4, lsat4, dneg4;
  logic [LIN_W-1:0]        lin4;
  logic [TAB_W-1:0]        lo4, delta4;

  always_comb begin
    dneg  = hi3 < lo3;
    dmag  = dneg ? (lo3 - hi3) : (hi3 - lo3);
    dprod = (TAB_W + FRAC_W)'(dmag) * (TAB_W + FRAC_W)'(f3);
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_DIFF]) begin
      neg4   <= neg3;
      knee4  <= knee3;
      lsat4  <= lsat3;
      lin4   <= lin3;
      lo4    <= lo3;
      dneg4  <= dneg;
      delta4 <= dprod[TAB_W+FRAC_W-1:FRAC_W];
    end
  end

  // stage: knee magnitude, clamp and sign
  logic [TAB_W:0]       t;
  logic [TAB_W+1:0]     m;
  logic [TAB_W+16:0]    ks;
  logic [17:0]          kmag;
  logic [LIN_W-1:0]     mag;
  logic [OUT_W-1:0]     out_next;

  always_comb begin
    t    = dneg4 ? ({1'b0, lo4} - {1'b0, delta4}) : ({1'b0, lo4} + {1'b0, delta4});
    m    = {1'b0, t} + (TAB_W + 2)'(Q30);
    ks   = {m, 15'b0} - {15'b0, m};
    kmag = ks[TAB_W+16:31];
    if (knee4) begin
      mag = (kmag > 18'(OUT_MAX)) ? OUT_MAX : kmag[LIN_W-1:0];
    end else begin
      mag = lsat4 ? OUT_MAX : lin4;
    end
    out_next = neg4 ? OUT_W'(-{1'b0, mag}) : {1'b0, mag};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_OUT]) begin
      sample_out <= out_next;
    end
  end

endmodule

FILE: sv/replay_gain_soft_limiter.sv
// Replay gain scaler with tanh soft limiter, top level
//
// Input channel in_valid/in_ready carries one signed Q1.23 sample per word.
// Output channel out_valid/out_ready carries one signed 16-bit sample per
// input word, in order. The config port (cfg_we, cfg_idx, cfg_data) writes
// gain_scale (index 0, Q4.16) or booster_enable (index 1) and
// is to be used only while no word is in flight.
// The pipeline has six register stages. Throughput is one word per cycle
// while the receiver takes every word, set by the fully pipelined gain
// multiply, tanh table lookup and interpolation multiply.
// Reset empties the pipeline, sets the gain to 1.0 and turns the booster
// off. The tanh table is a constant. When the receiver stalls, the output
// word holds and the stages behind it keep filling until each holds a
// word; in_ready then drops and nothing is lost or repeated.
`timescale 1ns / 1ps
module replay_gain_soft_limiter #(
  parameter int TANH_ENTRIES = rgsl_pkg::TANH_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [rgsl_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [rgsl_pkg::OUT_W-1:0]    sample_out,
  input  logic                                 cfg_we,
  input  logic        [rgsl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic        [rgsl_pkg::GAIN_W-1:0]   cfg_data
);
  import rgsl_pkg::*;

  logic [GAIN_W-1:0] gain_scale;
  logic              booster_enable;
  pipe_ctl_t         ctl;
  gain_bus_t         gbus;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_scale     <= GAIN_RESET;
      booster_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_GAIN_SCALE:     gain_scale     <= cfg_data;
        CFG_BOOSTER_ENABLE: booster_enable <= cfg_data[0];
      endcase
    end
  end

  rgsl_ctl u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  rgsl_gain u_gain (
    .clk            (clk),
    .ctl            (ctl),
    .sample_in      (sample_in),
    .gain_scale     (gain_scale),
    .booster_enable (booster_enable),
    .gbus           (gbus)
  );

  rgsl_knee #(
    .TANH_ENTRIES (TANH_ENTRIES)
  ) u_knee (
    .clk        (clk),
    .ctl        (ctl),
    .gbus       (gbus),
    .sample_out (sample_out)
  );

  assign in_ready  = ctl.en[ST_MUL];
  assign out_valid = ctl.vld[ST_OUT];

endmodule

FILE: sv/rgsl_chk.sv
// port-level checks for the replay gain soft limiter, bound to the top level
`timescale 1ns / 1ps
module rgsl_chk (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [rgsl_pkg::OUT_W-1:0]    sample_out
);
  import rgsl_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out))
    else $error("output word changed while stalled");

  // the clamp is symmetric, the most negative code never appears
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_out != {1'b1, {(OUT_W-1){1'b0}}})
    else $error("output reached the most negative code");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // a taking receiver never backs up the input
  a_flow: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output was taken");

endmodule

bind replay_gain_soft_limiter rgsl_chk u_rgsl_chk (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .sample_out (sample_out)
);

FILE: tb/sv/tb_top.sv
// self-checking testbench for the replay gain soft limiter
`timescale 1ns / 1ps
module tb_top;
  import rgsl_pkg::*;

  localparam int TANH_N    = TANH_ENTRIES_DEF;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 144;
  localparam int LONG_HOLD = 80;
  localparam int LIMIT     = 400000;

  localparam longint unsigned Q30_ONE  = 64'd1 << 30;
  localparam longint unsigned HALF_AMP = 64'd1 << 38;  // 0.5 in Q.39

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX  = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN  = 24'sh800000;
  localparam logic signed [SAMPLE_W-1:0] SMP_HALF = 24'sh400000;
  localparam logic signed [SAMPLE_W-1:0] SMP_QTR  = 24'sh200000;
  localparam logic [GAIN_W-1:0] GAIN_TOP = 20'hFFFFF;
  localparam logic [GAIN_W-1:0] GAIN_15  = 20'd983040;
  localparam logic [GAIN_W-1:0] GAIN_LOW = 20'd131072;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          gain;
    logic                       boost;
    bit                         typed;
    logic signed [OUT_W-1:0]    want;
  } vector_t;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [OUT_W-1:0]    sample_out;
  logic                       cfg_we;
  logic [CFG_IDX_W-1:0]       cfg_idx;
  logic [GAIN_W-1:0]          cfg_data;

  longint unsigned         tanh_pts [0:TANH_N];
  logic signed [OUT_W-1:0] expected_out [$];
  logic [GAIN_W-1:0]       cur_gain;
  logic                    cur_boost;
  idle_mode_t              idle_mode;
  bit                      hold_req;
  int                      err_cnt;
  int                      cycles;

  vector_t directed [23] = '{
    '{24'sd0,        GAIN_RESET, 1'b0, 1'b1, 16'sd0},
    '{SMP_MAX,       GAIN_RESET, 1'b0, 1'b1, 16'sd32766},
    '{SMP_MIN,       GAIN_RESET, 1'b0, 1'b1, -16'sd32767},
    '{24'sd1,        GAIN_RESET, 1'b0, 1'b1, 16'sd0},
    '{-24'sd1,       GAIN_RESET, 1'b0, 1'b1, 16'sd0},
    '{SMP_HALF,      GAIN_RESET, 1'b0, 1'b1, 16'sd16383},
    '{SMP_MAX,       20'd0,      1'b0, 1'b1, 16'sd0},
    '{SMP_MIN,       20'd0,      1'b0, 1'b1, 16'sd0},
    '{SMP_MAX,       GAIN_TOP,   1'b0, 1'b1, 16'sd32767},
    '{SMP_MIN,       GAIN_TOP,   1'b0, 1'b1, -16'sd32767},
    '{24'sd1,        GAIN_TOP,   1'b0, 1'b0, 16'sd0},
    '{24'sh100000,   GAIN_15,    1'b0, 1'b1, 16'sd32767},
    // exactly half after doubling stays on the linear side
    '{SMP_QTR,       GAIN_RESET, 1'b1, 1'b1, 16'sd16383},
    '{-SMP_QTR,      GAIN_RESET, 1'b1, 1'b1, -16'sd16383},
    '{24'sh200001,   GAIN_RESET, 1'b1, 1'b0, 16'sd0},
    '{SMP_HALF,      GAIN_RESET, 1'b1, 1'b0, 16'sd0},
    '{-24'sh600000,  GAIN_RESET, 1'b1, 1'b0, 16'sd0},
    '{SMP_MAX,       GAIN_RESET, 1'b1, 1'b0, 16'sd0},
    '{24'sd0,        GAIN_RESET, 1'b1, 1'b1, 16'sd0},
    // tanh argument past the last table point, then a point inside the table and zero gain
    '{SMP_MAX,       GAIN_TOP,   1'b1, 1'b0, 16'sd0},
    '{SMP_MIN,       GAIN_TOP,   1'b1, 1'b0, 16'sd0},
    '{24'sd200000,   GAIN_TOP,   1'b1, 1'b0, 16'sd0},
    '{SMP_MIN,       20'd0,      1'b1, 1'b1, 16'sd0}
  };

  replay_gain_soft_limiter u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void build_tanh_pts();
    longint unsigned step;
    longint unsigned term;
    longint unsigned decay;
    longint unsigned p;
    step  = (64'd16 << 30) / 64'(TANH_N);
    term  = Q30_ONE;
    decay = Q30_ONE;
    p     = Q30_ONE;
    // series for exp(-16/N)
    for (int n = 1; n <= 12; n++) begin
      term = ((term * step) >> 30) / 64'(n);
      if (n % 2) decay -= term;
      else decay += term;
    end
    tanh_pts[0] = 0;
    for (int k = 1; k <= TANH_N; k++) begin
      p = (p * decay) >> 30;
      tanh_pts[k] = ((Q30_ONE - p) << 30) / (Q30_ONE + p);
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] limit_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input logic [GAIN_W-1:0]          g,
    input logic                       b
  );
    logic            neg;
    longint unsigned mag;
    longint unsigned amp;
    longint unsigned u;
    longint unsigned pos;
    longint unsigned idx;
    longint unsigned f;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned t;
    longint unsigned m;
    logic [OUT_W-1:0] r;
    neg = s[SAMPLE_W-1];
    mag = {40'd0, s};
    if (neg) mag = (64'd1 << SAMPLE_W) - mag;
    amp = mag * 64'(g);
    if (b) amp = amp << 1;
    if (b && amp > HALF_AMP) begin
      u   = (amp - HALF_AMP) << 1;
      pos = u * 64'(TANH_N);
      idx = pos >> 42;
      if (idx >= 64'(TANH_N)) begin
        t = tanh_pts[TANH_N];
      end else begin
        f  = (pos >> 12) & (Q30_ONE - 1);
        lo = tanh_pts[idx];
        hi = tanh_pts[idx + 1];
        t  = (hi >= lo) ? lo + (((hi - lo) * f) >> 30) : lo - (((lo - hi) * f) >> 30);
      end
      m = ((t + Q30_ONE) * 64'(OUT_MAX)) >> 31;
    end else begin
      m = (amp * 64'(OUT_MAX)) >> 39;
    end
    if (m > 64'(OUT_MAX)) m = 64'(OUT_MAX);
    r = m[OUT_W-1:0];
    if (neg) r = -r;
    return signed'(r);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    logic signed [SAMPLE_W-1:0] s;
    int unsigned v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: s = SMP_MAX;
          1: s = SMP_MIN;
          2: s = 24'sd1;
          default: s = -24'sd1;
        endcase
      end
      1, 2, 3, 4: s = SAMPLE_W'($urandom);
      default: begin
        // spread magnitudes over all scales
        v = $urandom_range(0, 24'h7FFFFF) >> $urandom_range(0, 22);
        s = SAMPLE_W'(v);
        if ($urandom_range(0, 1)) s = -s;
      end
    endcase
    return s;
  endfunction

  task automatic load_settings(input logic [GAIN_W-1:0] g, input logic b);
    logic [GAIN_W-2:0] junk;
    junk = (GAIN_W - 1)'($urandom);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_GAIN_SCALE;
    cfg_data <= g;
    @(negedge clk);
    cfg_idx  <= CFG_BOOSTER_ENABLE;
    cfg_data <= {junk, b};
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_gain  = g;
    cur_boost = b;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (expected_out.size() != 0) @(negedge clk);
  endtask

  task automatic push_sample(
    input logic signed [SAMPLE_W-1:0] s,
    input bit                         typed,
    input logic signed [OUT_W-1:0]    want
  );
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 79 : (idle_mode == IDLE_BOTH) ? 6 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    expected_out.push_back(typed ? want : limit_sample(s, cur_gain, cur_boost));
    @(negedge clk);
  endtask

  // receiver side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idle_mode == IDLE_RECV) begin
        out_ready <= ($urandom_range(0, 99) >= 79);
      end else if (idle_mode == IDLE_BOTH) begin
        out_ready <= ($urandom_range(0, 99) >= 6);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_out.size() == 0) begin
        $error("sample_out with no word pending: actual %0d", sample_out);
        err_cnt++;
      end else begin
        if (sample_out !== expected_out[0]) begin
          $error("sample_out mismatch: expected %0d, actual %0d", expected_out[0], sample_out);
          err_cnt++;
        end
        void'(expected_out.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("replay_gain_soft_limiter verification failed");
      $finish;
    end
  end

  initial begin
    logic [GAIN_W-1:0] g;
    logic              b;
    rst       = 1'b1;
    in_valid  = 1'b0;
    sample_in = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_GAIN_SCALE;
    cfg_data  = '0;
    cur_gain  = GAIN_RESET;
    cur_boost = 1'b0;
    idle_mode = IDLE_NONE;
    hold_req  = 1'b0;
    err_cnt   = 0;
    cycles    = 0;
    build_tanh_pts();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].gain !== cur_gain || directed[i].boost !== cur_boost) begin
        wait_drained();
        load_settings(directed[i].gain, directed[i].boost);
      end
      push_sample(directed[i].sample, directed[i].typed, directed[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin idle_mode = IDLE_NONE; g = GAIN_RESET; b = 1'b1; end
        1: begin idle_mode = IDLE_SEND; g = GAIN_W'($urandom); b = 1'b0; end
        2: begin idle_mode = IDLE_RECV; g = GAIN_W'($urandom_range(0, GAIN_LOW)); b = 1'b1; end
        3: begin idle_mode = IDLE_BOTH; g = GAIN_TOP; b = 1'b1; end
        4: begin idle_mode = IDLE_NONE; g = GAIN_W'($urandom); b = 1'b1; end
        5: begin idle_mode = IDLE_SEND; g = GAIN_15; b = 1'b0; end
        6: begin idle_mode = IDLE_RECV; g = GAIN_W'($urandom); b = 1'($urandom_range(0, 1)); end
        default: begin idle_mode = IDLE_BOTH; g = GAIN_RESET; b = 1'b0; end
      endcase
      wait_drained();
      load_settings(g, b);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // long output stall while words keep coming, so the pipe backs up
        if (ph == 2 && n == 20) hold_req = 1'b1;
        if (ph == 4 && n == 70) wait_drained();
        push_sample(rand_sample(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4 * NSTG) @(negedge clk);
    if (err_cnt == 0) begin
      $display("replay_gain_soft_limiter verification clean");
    end else begin
      $display("replay_gain_soft_limiter verification failed");
    end
    $finish;
  end

endmodule
